// ----- src/cjre_pkg.sv -----
// Package with the payload types and constants of the Jacobian row emitter.
`timescale 1ns / 1ps
package cjre_pkg;

    localparam int unsigned DefNodeCount = 1024;
    localparam int unsigned DefRowCount  = 1024;

    localparam logic FUNC_DISTANCE = 1'b0;
    localparam logic FUNC_ANCHOR   = 1'b1;

    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    typedef struct packed {
        logic               func;
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic [9:0]         first_index;
        logic               first_present;
        logic [9:0]         second_index;
        logic               second_present;
        logic               second_anchored;
        logic [30:0]        rest_len;
        logic [9:0]         constraint_row;
    } t_in_item;

    typedef struct packed {
        logic [9:0]         matrix_row;
        logic [10:0]        matrix_column;
        logic signed [31:0] entry_value;
        logic               entry_valid;
        logic signed [31:0] constraint_error;
        logic               last;
    } t_out_item;

    // Per-constraint context carried beside the arithmetic.
    typedef struct packed {
        logic        anchor;
        logic        neg_x;
        logic        neg_y;
        logic        emit_first;
        logic        emit_second;
        logic [9:0]  first_index;
        logic [9:0]  second_index;
        logic [30:0] rest_len;
        logic [9:0]  row;
    } t_ctx;

endpackage

// ----- src/cjre_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module cjre_sqrt
    import cjre_pkg::*;
#(
    parameter int unsigned RW = 32,
    parameter int unsigned SW = 1
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [2*RW-1:0] i_rad,
    input  logic [SW-1:0]   i_side,
    output logic [RW-1:0]   o_root,
    output logic [SW-1:0]   o_side
);

    logic [2*RW-1:0] r_rad  [RW+1];
    logic [RW+1:0]   r_rem  [RW+1];
    logic [RW-1:0]   r_root [RW+1];
    logic [SW-1:0]   r_side [RW+1];

    always_comb begin
        r_rad[0]  = i_rad;
        r_rem[0]  = '0;
        r_root[0] = '0;
        r_side[0] = i_side;
    end

    // Each stage brings down the next two radicand bits and settles one root bit.
    for (genvar s = 0; s < RW; s++) begin : g_st
        logic [RW+3:0]   n_rem;
        logic [RW+3:0]   n_trial;
        logic            n_take;
        logic [2*RW-1:0] r_rad_q;
        logic [RW+1:0]   r_rem_q;
        logic [RW-1:0]   r_root_q;
        logic [SW-1:0]   r_side_q;
        always_comb begin
            n_rem   = {r_rem[s], r_rad[s][2*RW-1:2*RW-2]};
            n_trial = (RW+4)'({r_root[s], 2'b01});
            n_take  = n_rem >= n_trial;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad_q  <= r_rad[s] << 2;
                r_side_q <= r_side[s];
                if (n_take) begin
                    r_rem_q  <= (RW+2)'(n_rem - n_trial);
                    r_root_q <= {r_root[s][RW-2:0], 1'b1};
                end else begin
                    r_rem_q  <= (RW+2)'(n_rem);
                    r_root_q <= {r_root[s][RW-2:0], 1'b0};
                end
            end
        end
        always_comb begin
            r_rad[s+1]  = r_rad_q;
            r_rem[s+1]  = r_rem_q;
            r_root[s+1] = r_root_q;
            r_side[s+1] = r_side_q;
        end
    end

    assign o_root = r_root[RW];
    assign o_side = r_side[RW];

endmodule

// ----- src/constraint_jacobian_row_emitter.sv -----
// Top level of the constraint Jacobian row emitter.
//  channel | direction | signals
//  input   | in        | i_in_valid, o_in_ready, i_in_data
//  output  | out       | o_out_valid, i_out_ready, o_out_data
// Each constraint yields one to five result transactions, one per cycle while the output is ready.
// An accepted transaction passes one front stage, 32 square root stages,
// 32 divider stages and one output stage before it reaches the output.
// While a constraint drains its k results the input waits until its last result is taken.
// Reset clears all valid bits; the pipeline advances only when not stalled.
// A stall holds every stage, so nothing is lost or repeated.
`timescale 1ns / 1ps
module constraint_jacobian_row_emitter
    import cjre_pkg::*;
#(
    parameter int unsigned NODE_COUNT = DefNodeCount,
    parameter int unsigned ROW_COUNT  = DefRowCount
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int unsigned DEPTH = 1 + 32 + 32 + 1;

    logic en;
    logic [DEPTH-1:0] r_vld;
    logic [2:0] r_sent;
    logic       busy_emit;

    // Front end: differences, magnitudes, normalization.
    logic signed [32:0] dx, dy;
    logic [32:0] ax, ay, mx;
    logic [31:0] lx, ly, nx0, ny0;
    logic [4:0]  sh;
    t_ctx c0;
    always_comb begin
        dx = {i_in_data.second_x[31], i_in_data.second_x} - {i_in_data.first_x[31], i_in_data.first_x};
        dy = {i_in_data.second_y[31], i_in_data.second_y} - {i_in_data.first_y[31], i_in_data.first_y};
        ax = dx[32] ? 33'(-dx) : 33'(dx);
        ay = dy[32] ? 33'(-dy) : 33'(dy);
        mx = (ax > ay) ? ax : ay;
        // The highest set bit below bit 31 decides the normalizing shift.
        sh = '0;
        for (int b = 0; b <= 30; b++) begin
            if (mx[b]) sh = 5'(30 - b);
        end
        if (mx[32] || mx[31]) begin
            lx = 32'(ax >> 1); ly = 32'(ay >> 1);
            nx0 = lx; ny0 = ly;
        end else begin
            lx = ax[31:0]; ly = ay[31:0];
            nx0 = lx << sh; ny0 = ly << sh;
        end
        c0.anchor = i_in_data.func == FUNC_ANCHOR;
        c0.neg_x = dx[32];
        c0.neg_y = dy[32];
        c0.emit_first = 32'(i_in_data.constraint_row) < ROW_COUNT && i_in_data.first_present
            && 32'(i_in_data.first_index) < NODE_COUNT;
        c0.emit_second = !c0.anchor && 32'(i_in_data.constraint_row) < ROW_COUNT
            && i_in_data.second_present && !i_in_data.second_anchored
            && 32'(i_in_data.second_index) < NODE_COUNT;
        c0.first_index = i_in_data.first_index;
        c0.second_index = i_in_data.second_index;
        c0.rest_len = i_in_data.rest_len;
        c0.row = i_in_data.constraint_row;
    end

    logic [31:0] r_lx, r_ly, r_nx, r_ny;
    logic        r_big, r_zero;
    t_ctx        r_c0;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lx <= lx; r_ly <= ly; r_nx <= nx0; r_ny <= ny0;
            r_big <= mx[32] | mx[31];
            r_zero <= mx == '0;
            r_c0 <= c0;
        end
    end

    // Length and normalized length roots run side by side.
    localparam int unsigned CTXW = $bits(t_ctx) + 1;
    localparam int unsigned NRMW = 64 + 1;
    logic [31:0] len_root, ln_root;
    logic [CTXW-1:0] side_len;
    logic [NRMW-1:0] side_ln;
    logic [63:0] rad_len, rad_ln;
    always_comb begin
        rad_len = 64'(r_lx) * 64'(r_lx) + 64'(r_ly) * 64'(r_ly);
        rad_ln  = 64'(r_nx) * 64'(r_nx) + 64'(r_ny) * 64'(r_ny);
    end
    cjre_sqrt #(.RW(32), .SW(CTXW)) u_sq_len (
        .i_clk, .i_en(en), .i_rad(rad_len),
        .i_side({r_c0, r_big}), .o_root(len_root), .o_side(side_len));
    cjre_sqrt #(.RW(32), .SW(NRMW)) u_sq_ln (
        .i_clk, .i_en(en), .i_rad(rad_ln),
        .i_side({r_nx, r_ny, r_zero}), .o_root(ln_root), .o_side(side_ln));

    t_ctx c1;
    logic [31:0] s_nx, s_ny;
    logic s_big, s_zero;
    assign {c1, s_big} = side_len;
    assign {s_nx, s_ny, s_zero} = side_ln;

    // Restoring divider, one quotient bit per stage for both components.
    localparam int unsigned QW = 32;
    logic [63:0] d_rx [QW+1];
    logic [63:0] d_ry [QW+1];
    logic [31:0] d_qx [QW+1];
    logic [31:0] d_qy [QW+1];
    logic [31:0] d_dv [QW+1];
    logic [32:0] d_len[QW+1];
    t_ctx        d_c  [QW+1];
    logic        d_z  [QW+1];
    logic [63:0] numx, numy;
    always_comb begin
        numx = (64'(s_nx) << 30) + 64'(ln_root >> 1);
        numy = (64'(s_ny) << 30) + 64'(ln_root >> 1);
        d_rx[0] = numx; d_ry[0] = numy; d_qx[0] = '0; d_qy[0] = '0;
        d_dv[0] = ln_root;
        d_len[0] = s_big ? {len_root, 1'b0} : {1'b0, len_root};
        d_c[0] = c1;
        d_z[0] = s_zero;
    end
    for (genvar s = 0; s < QW; s++) begin : g_div
        localparam int unsigned B = QW - 1 - s;
        logic [95:0] tx, ty;
        logic [63:0] rx_q, ry_q;
        logic [31:0] qx_q, qy_q, dv_q;
        logic [32:0] len_q;
        t_ctx        c_q;
        logic        z_q;
        always_comb begin
            tx = 96'(d_dv[s]) << B;
            ty = 96'(d_dv[s]) << B;
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (d_dv[s] != '0 && 96'(d_rx[s]) >= tx) begin
                    rx_q <= d_rx[s] - 64'(tx); qx_q <= d_qx[s] | (32'd1 << B);
                end else begin
                    rx_q <= d_rx[s]; qx_q <= d_qx[s];
                end
                if (d_dv[s] != '0 && 96'(d_ry[s]) >= ty) begin
                    ry_q <= d_ry[s] - 64'(ty); qy_q <= d_qy[s] | (32'd1 << B);
                end else begin
                    ry_q <= d_ry[s]; qy_q <= d_qy[s];
                end
                dv_q <= d_dv[s]; len_q <= d_len[s]; c_q <= d_c[s]; z_q <= d_z[s];
            end
        end
        always_comb begin
            d_rx[s+1] = rx_q; d_ry[s+1] = ry_q; d_qx[s+1] = qx_q; d_qy[s+1] = qy_q;
            d_dv[s+1] = dv_q; d_len[s+1] = len_q; d_c[s+1] = c_q; d_z[s+1] = z_q;
        end
    end

    // Final stage: clamp, zero-length override, sign, error saturation.
    logic [31:0] qx, qy, vx, vy;
    logic signed [33:0] err_w;
    logic signed [31:0] err_s;
    t_ctx c2;
    always_comb begin
        c2 = d_c[QW];
        qx = (d_qx[QW] > ONE_Q30) ? ONE_Q30 : d_qx[QW];
        qy = (d_qy[QW] > ONE_Q30) ? ONE_Q30 : d_qy[QW];
        if (d_z[QW]) begin
            qx = '0; qy = '0;
        end
        vx = c2.neg_x ? -qx : qx;
        vy = c2.neg_y ? -qy : qy;
        err_w = c2.anchor ? 34'(d_len[QW]) : 34'(d_len[QW]) - 34'(c2.rest_len);
        if (err_w > 34'sd2147483647) err_s = 32'h7FFF_FFFF;
        else if (err_w < -34'sd2147483648) err_s = 32'h8000_0000;
        else err_s = err_w[31:0];
    end

    logic [31:0] r_vx, r_vy;
    logic signed [31:0] r_err;
    t_ctx r_c;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vx <= vx; r_vy <= vy; r_err <= err_s; r_c <= c2;
        end
    end

    // Pipeline control: the whole pipe advances unless the emit stage holds.
    logic tail_v;
    assign tail_v = r_vld[DEPTH-1];
    logic [2:0] n_cnt;
    always_comb begin
        n_cnt = 3'd1 + (r_c.emit_first ? 3'd2 : 3'd0) + (r_c.emit_second ? 3'd2 : 3'd0);
    end
    logic [2:0] kind;
    always_comb begin
        kind = 3'd4;
        if (r_c.emit_first && r_sent < 3'd2) kind = r_sent;
        else if (r_c.emit_second && r_sent < n_cnt - 3'd1)
            kind = 3'd2 + r_sent - (r_c.emit_first ? 3'd2 : 3'd0);
    end
    assign busy_emit = tail_v && !(i_out_ready && r_sent == n_cnt - 3'd1);
    assign en = !busy_emit;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_sent <= '0;
        end else begin
            if (en) r_vld <= {r_vld[DEPTH-2:0], i_in_valid};
            if (tail_v && i_out_ready) r_sent <= (r_sent == n_cnt - 3'd1) ? 3'd0 : r_sent + 3'd1;
        end
    end

    always_comb begin
        o_out_valid = tail_v;
        o_out_data = '0;
        o_out_data.matrix_row = r_c.row;
        case (kind)
            3'd0: begin
                o_out_data.matrix_column = {r_c.first_index, 1'b0};
                o_out_data.entry_value = r_vx; o_out_data.entry_valid = 1'b1;
            end
            3'd1: begin
                o_out_data.matrix_column = {r_c.first_index, 1'b1};
                o_out_data.entry_value = r_vy; o_out_data.entry_valid = 1'b1;
            end
            3'd2: begin
                o_out_data.matrix_column = {r_c.second_index, 1'b0};
                o_out_data.entry_value = -r_vx; o_out_data.entry_valid = 1'b1;
            end
            3'd3: begin
                o_out_data.matrix_column = {r_c.second_index, 1'b1};
                o_out_data.entry_value = -r_vy; o_out_data.entry_valid = 1'b1;
            end
            default: begin
                o_out_data.constraint_error = r_err; o_out_data.last = 1'b1;
            end
        endcase
    end

endmodule

// ----- tb/sv/jacobian_checker.sv -----
// Checker that predicts and compares the Jacobian row emitter's output transactions.
`timescale 1ns / 1ps
module jacobian_checker
    import cjre_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    t_out_item entry_queue[$];

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = '0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] unit_component(input logic [63:0] a,
                                                   input logic [63:0] ln,
                                                   input logic neg);
        logic [63:0] q;
        q = ((a << 30) + (ln >> 1)) / ln;
        if (q > 64'(ONE_Q30)) q = 64'(ONE_Q30);
        if (neg) q = -q;
        return q[31:0];
    endfunction

    task automatic predict_entries(input t_in_item it);
        logic signed [63:0] dx, dy, err;
        logic [63:0] ax, ay, mx, sx, sy, ln, len;
        logic [31:0] nx, ny;
        logic anchor, row_ok;
        t_out_item r;
        anchor = (it.func == FUNC_ANCHOR);
        dx = 64'(it.second_x) - 64'(it.first_x);
        dy = 64'(it.second_y) - 64'(it.first_y);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        mx = ax > ay ? ax : ay;
        nx = '0;
        ny = '0;
        if (mx >= 64'd1 << 31) begin
            sx = ax >> 1;
            sy = ay >> 1;
            ln = int_sqrt(sx * sx + sy * sy);
            len = ln << 1;
            nx = unit_component(sx, ln, dx < 0);
            ny = unit_component(sy, ln, dy < 0);
        end else begin
            len = int_sqrt(ax * ax + ay * ay);
            if (mx != 0) begin
                sx = ax;
                sy = ay;
                while (mx < 64'd1 << 30) begin
                    sx = sx << 1;
                    sy = sy << 1;
                    mx = mx << 1;
                end
                ln = int_sqrt(sx * sx + sy * sy);
                nx = unit_component(sx, ln, dx < 0);
                ny = unit_component(sy, ln, dy < 0);
            end
        end
        err = anchor ? $signed(len) : $signed(len) - $signed(64'(it.rest_len));
        if (err > 64'sd2147483647) err = 64'sd2147483647;
        if (err < -64'sd2147483648) err = -64'sd2147483648;
        row_ok = it.constraint_row < DefRowCount;
        r = '0;
        r.matrix_row = it.constraint_row;
        r.entry_valid = 1'b1;
        if (row_ok && it.first_present && it.first_index < DefNodeCount) begin
            r.matrix_column = {it.first_index, 1'b0};
            r.entry_value = nx;
            entry_queue.push_back(r);
            r.matrix_column = {it.first_index, 1'b1};
            r.entry_value = ny;
            entry_queue.push_back(r);
        end
        if (!anchor && row_ok && it.second_present && !it.second_anchored
                && it.second_index < DefNodeCount) begin
            r.matrix_column = {it.second_index, 1'b0};
            r.entry_value = -nx;
            entry_queue.push_back(r);
            r.matrix_column = {it.second_index, 1'b1};
            r.entry_value = -ny;
            entry_queue.push_back(r);
        end
        r = '0;
        r.matrix_row = it.constraint_row;
        r.constraint_error = err[31:0];
        r.last = 1'b1;
        entry_queue.push_back(r);
    endtask

    task automatic report(input t_out_item want, input t_out_item got);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("MISMATCH: expected %h actual %h", want, got);
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) predict_entries(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (entry_queue.size() == 0) begin
                    report('x, i_out_data);
                end else begin
                    want = entry_queue.pop_front();
                    if (want !== i_out_data) report(want, i_out_data);
                end
            end
        end
        o_pending = entry_queue.size();
    end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the Jacobian row emitter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench
    import cjre_pkg::*;
();

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;
    int        fail_count;
    int        pending;
    logic      calm = 1'b0;

    always #5 i_clk = ~i_clk;

    constraint_jacobian_row_emitter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data)
    );

    jacobian_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        out_ready <= calm || ($urandom_range(99) >= 8);
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
            3: return 32'($signed($urandom_range(64)) - 32);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item random_constraint();
        t_in_item it;
        it = $bits(t_in_item)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom});
        it.first_x = pick_coord();
        it.first_y = pick_coord();
        it.second_x = ($urandom_range(9) == 0) ? it.first_x : pick_coord();
        it.second_y = ($urandom_range(9) == 0) ? it.first_y : pick_coord();
        it.first_present = ($urandom_range(9) != 0);
        it.second_present = ($urandom_range(9) != 0);
        it.second_anchored = ($urandom_range(4) == 0);
        if ($urandom_range(3) == 0) it.rest_len = 31'($urandom_range(255) << 16);
        return it;
    endfunction

    // Holds the transaction until the block takes it; valid may drop between items unless calm is set.
    task automatic send(input t_in_item it);
        while (!calm && $urandom_range(99) < 8) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    initial begin
        t_in_item it;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed corners: zero length, extremes, absent or anchored nodes.
        for (int k = 0; k < 20; k++) begin
            it = '0;
            it.func = k[0];
            it.first_present = 1'b1;
            it.second_present = 1'b1;
            it.first_index = (k % 3 == 0) ? 10'h3ff : 10'(k);
            it.second_index = (k % 4 == 0) ? 10'h3ff : 10'(k + 7);
            it.constraint_row = (k % 5 == 0) ? 10'h3ff : 10'(k);
            it.rest_len = (k % 6 == 1) ? 31'h7fff_ffff : 31'(k << 16);
            case (k / 2)
                0: ;
                1: begin it.first_x = 32'h8000_0000; it.first_y = 32'h8000_0000;
                         it.second_x = 32'h7fff_ffff; it.second_y = 32'h7fff_ffff; end
                2: begin it.first_x = 32'h7fff_ffff; it.second_x = 32'h8000_0000; end
                3: begin it.second_x = 32'h0003_0000; it.second_y = 32'h0004_0000;
                         it.second_anchored = 1'b1; end
                4: begin it.second_y = 32'hffff_ffff; it.first_present = 1'b0; end
                5: begin it.second_x = 32'd1; it.second_present = 1'b0; end
                6: begin it.first_y = 32'h8000_0000; it.second_y = 32'h7fff_ffff;
                         it.rest_len = '0; end
                7: begin it.second_x = 32'hfffd_0000; it.second_y = 32'h0001_0000; end
                8: begin it.second_x = 32'h0000_0001; it.second_y = 32'h0000_0001; end
                default: begin it.first_x = 32'h7fff_ffff; it.first_y = 32'h8000_0000;
                         it.second_x = 32'h8000_0000; it.second_y = 32'h7fff_ffff; end
            endcase
            send(it);
        end
        for (int k = 0; k < 250; k++) begin
            calm <= (k >= 100 && k < 150);
            send(random_constraint());
        end
        in_valid <= 1'b0;
        calm <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #2ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/cjre_pkg.sv
src/cjre_sqrt.sv
src/constraint_jacobian_row_emitter.sv
tb/sv/jacobian_checker.sv
tb/sv/testbench.sv
